### rtl/sdeq_pkg.sv
// Shared types and constants for the sorted double-ended queue.
// Used by every module of the block and by its checker; depends on nothing.
package sdeq_pkg;

    localparam int CAPACITY   = 16;
    localparam int NAME_BYTES = 23;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_POP_MIN = 2'd1,
        MODE_POP_MAX = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic [63:0]        name_part0;
        logic [63:0]        name_part1;
        logic [55:0]        name_part2;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] out_key;
        logic [63:0]        out_name0;
        logic [63:0]        out_name1;
        logic [55:0]        out_name2;
        logic [4:0]         occupancy;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        name0;
        logic [63:0]        name1;
        logic [55:0]        name2;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic pop_min;
        logic head_ins;
    } cell_cmd_t;

endpackage

### rtl/sdeq_name_fmt.sv
// Name cleanup: zero every byte after the terminator and beyond NAME_BYTES.
// Depends on sdeq_pkg.
module sdeq_name_fmt
    import sdeq_pkg::*;
(
    input  logic [63:0] name_in0,
    input  logic [63:0] name_in1,
    input  logic [55:0] name_in2,
    output logic [63:0] name_out0,
    output logic [63:0] name_out1,
    output logic [55:0] name_out2
);

    logic [183:0] flat_in;
    logic [183:0] flat_out;

    assign flat_in = {name_in2, name_in1, name_in0};

    always_comb begin
        logic ended;
        ended    = 1'b0;
        flat_out = flat_in;
        for (int i = 0; i < 23; i++) begin
            if (ended || i >= NAME_BYTES) begin
                flat_out[i*8 +: 8] = 8'd0;
            end else if (flat_in[i*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
    end

    assign name_out0 = flat_out[63:0];
    assign name_out1 = flat_out[127:64];
    assign name_out2 = flat_out[183:128];

endmodule

### rtl/sdeq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the new key,
// and loads from the new item, its left neighbor or its right neighbor. Uses sdeq_pkg.
module sdeq_cell
    import sdeq_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      is_head,
    input  logic      occupied,
    input  entry_t    new_ent,
    input  logic      left_after,
    input  entry_t    left_ent,
    input  entry_t    right_ent,
    output entry_t    ent,
    output logic      after
);

    entry_t ent_reg;
    entry_t ent_next;

    assign after = is_head ? cmd.head_ins
                 : (cmd.head_ins || !occupied || !(ent_reg.key < new_ent.key));

    always_comb begin
        ent_next = ent_reg;
        if (cmd.ins) begin
            if (after && left_after) begin
                ent_next = left_ent;
            end else if (after) begin
                ent_next = new_ent;
            end
        end else if (cmd.pop_min) begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

### rtl/sorted_double_ended_queue.sv
// Sorted double-ended queue: a chain of 16 entry cells kept in ascending key order.
// Depends on sdeq_pkg, sdeq_cell and sdeq_name_fmt.
//
// Input channel s_valid/s_ready/s_data carries one operation: insert, pop smallest
// or pop largest. Output channel m_valid/m_ready/m_data returns exactly one result
// per operation: status, the removed entry (zero for inserts and errors) and the
// number of stored entries afterwards.
// Every cell compares its key with the new key in parallel and shifts in the same
// cycle, so the result appears in the output register on the cycle after the
// transfer, and one operation per cycle is taken while the receiver keeps m_ready
// high.
// When the receiver stalls, the result is held in the output register and
// s_ready drops until it is taken.
// Reset (aresetn low, synchronous) empties the store and clears the output valid;
// entry contents are not cleared.
module sorted_double_ended_queue
    import sdeq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    cell_cmd_t        cmd;
    entry_t           new_ent;
    entry_t           ent [CAPACITY];
    logic [CAPACITY-1:0] after_vec;
    logic [IDX_W-1:0] last_idx;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    sdeq_name_fmt u_name_fmt (
        .name_in0  (s_data.name_part0),
        .name_in1  (s_data.name_part1),
        .name_in2  (s_data.name_part2),
        .name_out0 (new_ent.name0),
        .name_out1 (new_ent.name1),
        .name_out2 (new_ent.name2)
    );
    assign new_ent.key = s_data.key;

    assign cmd.ins      = accept && (s_data.mode == MODE_INSERT) && !is_full;
    assign cmd.pop_min  = accept && (s_data.mode == MODE_POP_MIN) && !is_empty;
    assign cmd.head_ins = is_empty || (s_data.key < ent[0].key);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_after;
        entry_t left_ent;
        entry_t right_ent;

        if (g == 0) begin : g_first
            assign left_after = 1'b0;
            assign left_ent   = '0;
        end else begin : g_inner
            assign left_after = after_vec[g-1];
            assign left_ent   = ent[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_body
            assign right_ent = ent[g+1];
        end

        sdeq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .is_head    (g == 0),
            .occupied   (CNT_W'(g) < count_reg),
            .new_ent    (new_ent),
            .left_after (left_after),
            .left_ent   (left_ent),
            .right_ent  (right_ent),
            .ent        (ent[g]),
            .after      (after_vec[g])
        );
    end

    always_comb begin
        count_next  = count_reg;
        m_data_next = '0;
        m_data_next.status = ST_DONE;
        case (s_data.mode)
            MODE_INSERT: begin
                if (is_full) begin
                    m_data_next.status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP_MIN: begin
                if (is_empty) begin
                    m_data_next.status = ST_EMPTY;
                end else begin
                    count_next            = count_reg - CNT_W'(1);
                    m_data_next.out_key   = ent[0].key;
                    m_data_next.out_name0 = ent[0].name0;
                    m_data_next.out_name1 = ent[0].name1;
                    m_data_next.out_name2 = ent[0].name2;
                end
            end
            MODE_POP_MAX: begin
                if (is_empty) begin
                    m_data_next.status = ST_EMPTY;
                end else begin
                    count_next            = count_reg - CNT_W'(1);
                    m_data_next.out_key   = ent[last_idx].key;
                    m_data_next.out_name0 = ent[last_idx].name0;
                    m_data_next.out_name1 = ent[last_idx].name1;
                    m_data_next.out_name2 = ent[last_idx].name2;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        m_data_next.occupancy = 5'(count_next);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/sdeq_checker.sv
// Port-level checker for the sorted double-ended queue, bound to the top level.
// Depends on sdeq_pkg and sorted_double_ended_queue.
module sdeq_props
    import sdeq_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.occupancy <= 5'(CAPACITY))
        else $error("occupancy above capacity");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |->
            m_data.occupancy == 5'd0 && m_data.out_key == 32'sd0)
        else $error("empty status with nonzero fields");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> m_data.occupancy == 5'(CAPACITY))
        else $error("full status below capacity");

endmodule

bind sorted_double_ended_queue sdeq_props u_sdeq_props (.*);
